// ===== design/satq_pkg.sv =====
// ============================================================================
// satq_pkg - shared types and constants for the sorted alarm timer queue
// Command codes, field widths and the controller/datapath handshake structs.
// ============================================================================
`default_nettype none

package satq_pkg;

	// Field widths
	localparam int CMD_W     = 2;
	localparam int DELAY_W   = 20;
	localparam int HANDLER_W = 8;
	localparam int PARAM_W   = 32;
	localparam int CTIME_W   = 20;
	localparam int ATIME_W   = 22;
	localparam int POPS_W    = 5;

	// Most results one tick may produce
	localparam int MAX_RESULTS = 16;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_START = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	// Result kinds
	localparam logic EVT_FIRED = 1'b0;
	localparam logic EVT_ERROR = 1'b1;

	// Controller -> datapath commands
	typedef struct packed {
		logic latch;    // capture the incoming transaction
		logic tick;     // advance time, rebase on wrap, clear pop count
		logic insert;   // insert the latched alarm into the sorted pool
		logic error;    // emit an out-of-timers result
		logic clear;    // drop every pending alarm
		logic pop;      // emit the head alarm and shift the pool down
	} ctrl_cmd_t;

	// Datapath -> controller status
	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic             full;
		logic             head_expired;
		logic             out_free;
	} ctrl_status_t;

endpackage

`default_nettype wire

// ===== design/satq_if.sv =====
// ============================================================================
// satq_if - request and result channel interfaces
// Valid/ready channels; a transaction moves when valid and ready are high.
// ============================================================================
`default_nettype none

interface satq_req_if
	import satq_pkg::*;
	;
	logic                        valid;
	logic                        ready;
	logic [CMD_W-1:0]            command;
	logic [DELAY_W-1:0]          delay;
	logic [HANDLER_W-1:0]        handler_id;
	logic signed [PARAM_W-1:0]   handler_param;

	modport source (output valid, command, delay, handler_id, handler_param, input ready);
	modport sink   (input valid, command, delay, handler_id, handler_param, output ready);
endinterface

interface satq_rsp_if
	import satq_pkg::*;
	;
	logic                        valid;
	logic                        ready;
	logic                        event_kind;
	logic [HANDLER_W-1:0]        fired_handler;
	logic signed [PARAM_W-1:0]   fired_param;
	logic                        last_of_run;

	modport source (output valid, event_kind, fired_handler, fired_param, last_of_run,
		input ready);
	modport sink   (input valid, event_kind, fired_handler, fired_param, last_of_run,
		output ready);
endinterface

`default_nettype wire

// ===== design/satq_ctrl.sv =====
// ============================================================================
// satq_ctrl - sequencing state machine for the alarm queue
// Takes one transaction at a time, runs it, and walks the pop loop of a tick.
// ============================================================================
`default_nettype none

module satq_ctrl
	import satq_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         req_valid,
	output logic              req_ready,
	input  wire ctrl_status_t status,
	output ctrl_cmd_t         cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_POP  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	// Next state and command decode
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (status.command)
					CMD_TICK: begin
						cmd.tick  = 1'b1;
						state_nxt = ST_POP;
					end
					CMD_START: begin
						if (!status.full) begin
							cmd.insert = 1'b1;
							state_nxt  = ST_IDLE;
						end else if (status.out_free) begin
							cmd.error = 1'b1;
							state_nxt = ST_IDLE;
						end
					end
					CMD_CLEAR: begin
						cmd.clear = 1'b1;
						state_nxt = ST_IDLE;
					end
					default: state_nxt = ST_IDLE;
				endcase
			end
			ST_POP: begin
				if (!status.head_expired) begin
					state_nxt = ST_IDLE;
				end else if (status.out_free) begin
					cmd.pop = 1'b1;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

// ===== design/satq_dp.sv =====
// ============================================================================
// satq_dp - datapath of the alarm queue
// Row of sorted alarm cells, time base, entry count and the result register.
// ============================================================================
`default_nettype none

module satq_dp
	import satq_pkg::*;
#(
	parameter int DEPTH    = 16,
	parameter int WRAP_CNT = 1000000
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire ctrl_cmd_t                 cmd,
	output ctrl_status_t                   status,
	input  wire logic [CMD_W-1:0]          req_command,
	input  wire logic [DELAY_W-1:0]        req_delay,
	input  wire logic [HANDLER_W-1:0]      req_handler,
	input  wire logic signed [PARAM_W-1:0] req_param,
	satq_rsp_if.source                     rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [ATIME_W-1:0] WRAP_T = ATIME_W'(WRAP_CNT);

	// Latched transaction
	logic [CMD_W-1:0]          command_q;
	logic [DELAY_W-1:0]        delay_q;
	logic [HANDLER_W-1:0]      handler_q;
	logic signed [PARAM_W-1:0] param_q;

	// Control state
	logic [CTIME_W-1:0] ctime_q;
	logic [CNT_W-1:0]   count_q;
	logic [POPS_W-1:0]  pops_q;

	// Alarm cells, sorted earliest first
	logic [ATIME_W-1:0]        time_q    [DEPTH];
	logic [HANDLER_W-1:0]      handler_a [DEPTH];
	logic signed [PARAM_W-1:0] param_a   [DEPTH];
	logic [ATIME_W-1:0]        time_nxt  [DEPTH];
	logic [HANDLER_W-1:0]      hdl_nxt   [DEPTH];
	logic signed [PARAM_W-1:0] prm_nxt   [DEPTH];
	logic [ATIME_W-1:0]        time_up   [DEPTH];
	logic [HANDLER_W-1:0]      hdl_up    [DEPTH];
	logic signed [PARAM_W-1:0] prm_up    [DEPTH];
	logic [ATIME_W-1:0]        time_dn   [DEPTH];
	logic [HANDLER_W-1:0]      hdl_dn    [DEPTH];
	logic signed [PARAM_W-1:0] prm_dn    [DEPTH];
	logic [DEPTH:0]            le_ext;

	// Result register
	logic                      out_valid_q;
	logic                      out_kind_q;
	logic [HANDLER_W-1:0]      out_hdl_q;
	logic signed [PARAM_W-1:0] out_prm_q;
	logic                      out_last_q;

	logic [ATIME_W-1:0] new_time;
	logic [ATIME_W-1:0] ctime_ext;
	logic [ATIME_W-1:0] ctime_inc;
	logic               wrap_hit;
	logic               out_free;
	logic               head_expired;
	logic               next_expired;
	logic               cells_we;

	// Time arithmetic
	assign ctime_ext = ATIME_W'(ctime_q);
	assign new_time  = ctime_ext + ATIME_W'(delay_q);
	assign ctime_inc = ctime_ext + ATIME_W'(1);
	assign wrap_hit  = (ctime_inc >= WRAP_T);

	// Head expiry, and whether the entry behind it will follow
	assign head_expired = (count_q != '0) && (pops_q < POPS_W'(MAX_RESULTS))
		&& (ctime_ext >= time_q[0]);
	assign next_expired = (count_q > CNT_W'(1)) && (pops_q < POPS_W'(MAX_RESULTS - 1))
		&& (ctime_ext >= time_dn[0]);

	assign out_free = !out_valid_q || rsp.ready;

	assign status.command      = command_q;
	assign status.full         = (count_q == CNT_W'(DEPTH));
	assign status.head_expired = head_expired;
	assign status.out_free     = out_free;

	assign cells_we = cmd.insert || cmd.pop || (cmd.tick && wrap_hit);
	assign le_ext[0] = 1'b1;

	// Per-cell neighbor taps and next value
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign le_ext[i+1] = (count_q > CNT_W'(i)) && (time_q[i] <= new_time);

		if (i == 0) begin : g_first
			assign time_up[i] = '0;
			assign hdl_up[i]  = '0;
			assign prm_up[i]  = '0;
		end else begin : g_mid
			assign time_up[i] = time_q[i-1];
			assign hdl_up[i]  = handler_a[i-1];
			assign prm_up[i]  = param_a[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign time_dn[i] = time_q[i];
			assign hdl_dn[i]  = handler_a[i];
			assign prm_dn[i]  = param_a[i];
		end else begin : g_body
			assign time_dn[i] = time_q[i+1];
			assign hdl_dn[i]  = handler_a[i+1];
			assign prm_dn[i]  = param_a[i+1];
		end

		always_comb begin
			time_nxt[i] = time_q[i];
			hdl_nxt[i]  = handler_a[i];
			prm_nxt[i]  = param_a[i];
			if (cmd.insert) begin
				if (le_ext[i+1]) begin
					// earlier or equal alarm stays put
				end else if (le_ext[i]) begin
					time_nxt[i] = new_time;
					hdl_nxt[i]  = handler_q;
					prm_nxt[i]  = param_q;
				end else begin
					time_nxt[i] = time_up[i];
					hdl_nxt[i]  = hdl_up[i];
					prm_nxt[i]  = prm_up[i];
				end
			end else if (cmd.pop) begin
				time_nxt[i] = time_dn[i];
				hdl_nxt[i]  = hdl_dn[i];
				prm_nxt[i]  = prm_dn[i];
			end else begin
				// rebase on wrap, saturating at zero
				time_nxt[i] = (time_q[i] >= WRAP_T) ? (time_q[i] - WRAP_T) : '0;
			end
		end
	end

	// Cell storage
	always_ff @(posedge clk) begin
		if (cells_we) begin
			for (int i = 0; i < DEPTH; i++) begin
				time_q[i]    <= time_nxt[i];
				handler_a[i] <= hdl_nxt[i];
				param_a[i]   <= prm_nxt[i];
			end
		end
	end

	// Transaction capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			command_q <= CMD_TICK;
		end else if (cmd.latch) begin
			command_q <= req_command;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			delay_q   <= req_delay;
			handler_q <= req_handler;
			param_q   <= req_param;
		end
	end

	// Time base, entry count, pop count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctime_q <= '0;
			count_q <= '0;
			pops_q  <= '0;
		end else begin
			if (cmd.tick) begin
				ctime_q <= wrap_hit ? CTIME_W'(ctime_inc - WRAP_T) : CTIME_W'(ctime_inc);
				pops_q  <= '0;
			end
			if (cmd.insert) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.pop) begin
				count_q <= count_q - CNT_W'(1);
				pops_q  <= pops_q + POPS_W'(1);
			end else if (cmd.clear) begin
				count_q <= '0;
			end
		end
	end

	// Result register: holds one transaction until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.pop || cmd.error) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			out_kind_q <= EVT_FIRED;
			out_hdl_q  <= handler_a[0];
			out_prm_q  <= param_a[0];
			out_last_q <= !next_expired;
		end else if (cmd.error) begin
			out_kind_q <= EVT_ERROR;
			out_hdl_q  <= '0;
			out_prm_q  <= '0;
			out_last_q <= 1'b1;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.event_kind    = out_kind_q;
	assign rsp.fired_handler = out_hdl_q;
	assign rsp.fired_param   = out_prm_q;
	assign rsp.last_of_run   = out_last_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above pool depth");

	a_time_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctime_ext < WRAP_T)
		else $error("current time not below wrap value");

	a_pop_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pop || cmd.error) |-> out_free)
		else $error("result issued while result register busy");

	a_pop_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |=> pops_q <= POPS_W'(MAX_RESULTS))
		else $error("pop count above run limit");

	if (DEPTH > 1) begin : g_sorted_chk
		a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
			(count_q > CNT_W'(1)) |-> (time_q[0] <= time_q[1]))
			else $error("head alarms out of order");
	end

endmodule

`default_nettype wire

// ===== design/sorted_alarm_timer_queue.sv =====
// ============================================================================
// sorted_alarm_timer_queue - sorted pool of one-shot alarms
// Top level: state machine controller plus alarm-cell datapath.
// ============================================================================
// Usage:
//   req carries one command per transaction: tick, start alarm, or clear.
//   rsp carries results: fired alarms (handler, parameter) or an
//   out-of-timers error; last_of_run marks the final result of a command.
//   Start and clear produce no result except the error on a full pool.
// Timing:
//   One transaction is worked at a time: captured in the idle state, then run
//   in the exec state, where start and clear finish and return to idle.
//   A tick then moves to the pop state, which pops up to MAX_RESULTS expired
//   alarms, one per cycle while rsp is not stalled, then returns to idle.
//   Inserts and pops update every cell of the sorted row in parallel, one
//   shift per cycle; that pop loop sets the tick cost.
// Results:
//   Each result lands in an output register in the cycle after it is chosen.
//   While rsp is stalled the pop loop waits; the next request is still taken
//   once the current one is done.
// Reset:
//   arst_n clears the time base, entry count and controller; the pool is
//   empty afterward and ready at once.
// ============================================================================
`default_nettype none

module sorted_alarm_timer_queue
	import satq_pkg::*;
#(
	parameter int QUEUE_DEPTH     = 16,
	parameter int TIME_WRAP_COUNT = 1000000
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	satq_req_if.sink   req,
	satq_rsp_if.source rsp
);

	ctrl_cmd_t    cmd;
	ctrl_status_t status;
	logic         req_ready;

	assign req.ready = req_ready;

	// Controller
	satq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath
	satq_dp #(
		.DEPTH    (QUEUE_DEPTH),
		.WRAP_CNT (TIME_WRAP_COUNT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.req_command (req.command),
		.req_delay   (req.delay),
		.req_handler (req.handler_id),
		.req_param   (req.handler_param),
		.rsp         (rsp)
	);

endmodule

`default_nettype wire
